// ----- rtl/core/hbc_pkg.sv -----
// Shared constants, types and a helper function of the bucketed histogram counter.
`timescale 1ns / 1ps

package hbc_pkg;

	localparam int MAX_BUCKETS  = 8;
	localparam int HW_BUCKETS   = 8;
	localparam int NUM_BOUNDS   = 7;
	localparam int BUCKETS_USED = (MAX_BUCKETS < HW_BUCKETS) ? MAX_BUCKETS : HW_BUCKETS;
	localparam int BIDX_W       = $clog2(BUCKETS_USED);

	localparam int SAMPLE_W     = 48;
	localparam int CNT_W        = 63;
	localparam int SUM_W        = 64;
	localparam int IDX_W        = 3;
	localparam int NBKT_W       = 4;

	localparam int CFG_W        = 48;
	localparam int CFG_IDX_W    = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 3'd0;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_DUMP   = 1'b1;

	localparam int Q_DEPTH      = 2;
	localparam int Q_PTR_W      = 1;
	localparam int Q_CNT_W      = 2;

	typedef struct packed {
		logic                       dump;
		logic                       ignored;
		logic [BIDX_W-1:0]          last_idx;
		logic [BIDX_W-1:0]          hit;
		logic signed [SAMPLE_W-1:0] sample;
	} op_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ----- rtl/core/hbc_front.sv -----
// Front end: configuration registers, bucket classification and queue push.
`timescale 1ns / 1ps

module hbc_front import hbc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cmd,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       q_full,
	output logic                       push,
	output op_t                        push_op
);

	logic [NBKT_W-1:0]          bucket_count_q;
	logic signed [SAMPLE_W-1:0] bound_q [NUM_BOUNDS];
	logic [NBKT_W-1:0]          n_in_use;
	logic [BIDX_W-1:0]          last_idx;
	logic [BIDX_W-1:0]          hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= '0;
			for (int i = 0; i < NUM_BOUNDS; i++) begin
				bound_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_BUCKET_COUNT) begin
				bucket_count_q <= cfg_data[NBKT_W-1:0];
			end
			for (int i = 0; i < NUM_BOUNDS; i++) begin
				if (cfg_index == CFG_IDX_W'(i + 1)) begin
					bound_q[i] <= cfg_data[SAMPLE_W-1:0];
				end
			end
		end
	end

	assign n_in_use = (bucket_count_q > NBKT_W'(BUCKETS_USED)) ? NBKT_W'(BUCKETS_USED)
	                                                           : bucket_count_q;
	assign last_idx = BIDX_W'(n_in_use - NBKT_W'(1));

	// first boundary above the sample wins; catch-all otherwise
	always_comb begin
		hit = last_idx;
		for (int i = BUCKETS_USED - 2; i >= 0; i--) begin
			if ((BIDX_W'(i) < last_idx) && (sample < bound_q[i])) begin
				hit = BIDX_W'(i);
			end
		end
	end

	assign in_ready         = !q_full;
	assign push             = in_valid && in_ready;
	assign push_op.dump     = (cmd == CMD_DUMP);
	assign push_op.ignored  = (n_in_use == '0);
	assign push_op.last_idx = last_idx;
	assign push_op.hit      = hit;
	assign push_op.sample   = sample;

endmodule

// ----- rtl/core/hbc_queue.sv -----
// Two-entry operation queue between the front end and the back end.
`timescale 1ns / 1ps

module hbc_queue import hbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	output logic q_valid,
	output op_t  q_op,
	input  logic pop
);

	op_t                entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full    = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ----- rtl/core/hbc_back.sv -----
// Back end: bucket counters, total count, saturating sum and result register.
`timescale 1ns / 1ps

module hbc_back import hbc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  op_t                     q_op,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [IDX_W-1:0]        bucket_index,
	output logic [CNT_W-1:0]        bucket_total,
	output logic [CNT_W-1:0]        sample_total,
	output logic signed [SUM_W-1:0] value_sum,
	output logic                    ignored,
	output logic                    last
);

	logic [CNT_W-1:0]        cnt_q [BUCKETS_USED];
	logic [CNT_W-1:0]        sample_cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [BIDX_W-1:0]       dump_idx_q;

	logic                    out_valid_q;
	logic [IDX_W-1:0]        bucket_index_q;
	logic [CNT_W-1:0]        bucket_total_q;
	logic [CNT_W-1:0]        sample_total_q;
	logic signed [SUM_W-1:0] value_sum_q;
	logic                    ignored_q;
	logic                    last_q;

	logic                    fire;
	logic                    record;
	logic                    final_beat;
	logic [BIDX_W-1:0]       sel;
	logic [CNT_W-1:0]        cur_cnt;
	logic [CNT_W-1:0]        next_cnt;
	logic [CNT_W-1:0]        next_samples;
	logic signed [SUM_W-1:0] ext;
	logic signed [SUM_W-1:0] raw_sum;
	logic signed [SUM_W-1:0] next_sum;

	assign fire       = q_valid && (!out_valid_q || out_ready);
	assign record     = !q_op.dump && !q_op.ignored;
	assign final_beat = !q_op.dump || q_op.ignored || (dump_idx_q == q_op.last_idx);
	assign q_pop      = fire && final_beat;

	assign sel          = q_op.dump ? dump_idx_q : q_op.hit;
	assign cur_cnt      = cnt_q[sel];
	assign next_cnt     = sat_inc(cur_cnt);
	assign next_samples = sat_inc(sample_cnt_q);

	assign ext     = {{(SUM_W - SAMPLE_W){q_op.sample[SAMPLE_W-1]}}, q_op.sample};
	assign raw_sum = sum_q + ext;

	always_comb begin
		next_sum = raw_sum;
		if ((sum_q[SUM_W-1] == ext[SUM_W-1]) && (raw_sum[SUM_W-1] != sum_q[SUM_W-1])) begin
			next_sum = sum_q[SUM_W-1] ? {1'b1, {(SUM_W - 1){1'b0}}}
			                          : {1'b0, {(SUM_W - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUCKETS_USED; i++) begin
				cnt_q[i] <= '0;
			end
			sample_cnt_q <= '0;
			sum_q        <= '0;
			dump_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				if (record) begin
					cnt_q[sel]   <= next_cnt;
					sample_cnt_q <= next_samples;
					sum_q        <= next_sum;
				end
				if (q_op.dump && !q_op.ignored) begin
					dump_idx_q <= final_beat ? '0 : dump_idx_q + BIDX_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			bucket_index_q <= q_op.ignored ? '0 : IDX_W'(sel);
			bucket_total_q <= q_op.ignored ? '0 : (record ? next_cnt : cur_cnt);
			sample_total_q <= record ? next_samples : sample_cnt_q;
			value_sum_q    <= record ? next_sum : sum_q;
			ignored_q      <= q_op.ignored;
			last_q         <= final_beat;
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_index_q;
	assign bucket_total = bucket_total_q;
	assign sample_total = sample_total_q;
	assign value_sum    = value_sum_q;
	assign ignored      = ignored_q;
	assign last         = last_q;

endmodule

// ----- rtl/core/bucketed_histogram_counter.sv -----
// Top level of the bucketed histogram counter.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------------
//  in       | in_valid / in_ready    | cmd, sample
//  out      | out_valid / out_ready  | bucket_index, bucket_total, sample_total,
//           |                        | value_sum, ignored, last
//  cfg      | cfg_wr_en              | cfg_index, cfg_data
//
// A record yields one beat from the back end; a dump yields one beat per bucket in use
// (a single ignored beat when none is), one per cycle while the output is not stalled,
// set by the single read port of the counter bank. Records run at one per cycle in steady
// state while out_ready is held; the two-entry queue lets input beats land while stalled.
// Reset clears configuration, counters, the sum and the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module bucketed_histogram_counter import hbc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cmd,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [IDX_W-1:0]           bucket_index,
	output logic [CNT_W-1:0]           bucket_total,
	output logic [CNT_W-1:0]           sample_total,
	output logic signed [SUM_W-1:0]    value_sum,
	output logic                       ignored,
	output logic                       last
);

	logic push;
	op_t  push_op;
	logic q_full;
	logic q_valid;
	op_t  q_op;
	logic q_pop;

	hbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.sample    (sample),
		.q_full    (q_full),
		.push      (push),
		.push_op   (push_op)
	);

	hbc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.q_valid (q_valid),
		.q_op    (q_op),
		.pop     (q_pop)
	);

	hbc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_op         (q_op),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index),
		.bucket_total (bucket_total),
		.sample_total (sample_total),
		.value_sum    (value_sum),
		.ignored      (ignored),
		.last         (last)
	);

endmodule

// ----- rtl/core/hbc_checker.sv -----
// Port-level checker for the bucketed histogram counter, bound to the top level.
`timescale 1ns / 1ps

module hbc_checker import hbc_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [IDX_W-1:0]           bucket_index,
	input logic [CNT_W-1:0]           bucket_total,
	input logic [CNT_W-1:0]           sample_total,
	input logic signed [SUM_W-1:0]    value_sum,
	input logic                       ignored,
	input logic                       last
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input beat dropped while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bucket_total) && $stable(last)
			&& $stable(value_sum) && $stable(bucket_index))
		else $error("output beat changed while stalled");

	a_ignored_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ignored |-> last && (bucket_index == '0) && (bucket_total == '0))
		else $error("ignored beat not a single empty beat");

	a_run_not_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !ignored)
		else $error("multi-beat run carries ignored");

	a_bucket_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bucket_total <= sample_total)
		else $error("bucket count exceeds total count");

endmodule

bind bucketed_histogram_counter hbc_checker u_hbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.bucket_index (bucket_index),
	.bucket_total (bucket_total),
	.sample_total (sample_total),
	.value_sum    (value_sum),
	.ignored      (ignored),
	.last         (last)
);
